>>> rtl/pims_pkg.sv
// pims_pkg: constants and types shared by the packet image marker scanner.
// No dependencies.
`default_nettype none

package pims_pkg;

    localparam int IDX_W = 16;
    localparam int LEN_W = 16;

    // Fixed header byte positions
    localparam logic [IDX_W-1:0] POS_VER_IHL  = 16'd0;
    localparam logic [IDX_W-1:0] POS_LEN_HI   = 16'd2;
    localparam logic [IDX_W-1:0] POS_LEN_LO   = 16'd3;
    localparam logic [IDX_W-1:0] POS_PROTO    = 16'd9;
    localparam logic [IDX_W-1:0] POS_TCP_OFF  = 16'd32;
    localparam logic [IDX_W-1:0] POS_TCP_FLAG = 16'd33;
    localparam logic [IDX_W-1:0] IDX_MAX      = 16'hffff;

    // Mark patterns, newest byte in the low byte
    localparam logic [23:0] JPEG_SOI = 24'hffd8ff;
    localparam logic [31:0] GIF_SIG  = 32'h47494638;
    localparam logic [15:0] JPEG_EOI = 16'hffd9;

    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [3:0] IHL_MIN     = 4'd5;
    localparam logic [6:0] IP_HDR_LEN  = 7'd20;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] offset;
    } pims_mark_t;

    typedef struct packed {
        logic             accepted;
        logic             start_found;
        logic [LEN_W-1:0] start_offset;
        logic             end_found;
        logic [LEN_W-1:0] end_offset;
    } pims_result_t;

endpackage

`default_nettype wire

>>> rtl/pims_in_if.sv
// pims_in_if: packet byte channel (valid/ready plus byte and last flag).
// No dependencies.
`default_nettype none

interface pims_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       pkt_last;

    modport source (output valid, output pkt_byte, output pkt_last, input ready);
    modport sink   (input valid, input pkt_byte, input pkt_last, output ready);
endinterface

`default_nettype wire

>>> rtl/pims_out_if.sv
// pims_out_if: per-packet result channel (valid/ready plus result fields).
// No dependencies.
`default_nettype none

interface pims_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        start_found;
    logic [15:0] start_offset;
    logic        end_found;
    logic [15:0] end_offset;

    modport source (output valid, output accepted, output start_found,
                    output start_offset, output end_found, output end_offset,
                    input ready);
    modport sink   (input valid, input accepted, input start_found,
                    input start_offset, input end_found, input end_offset,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pims_scan.sv
// pims_scan: per-packet header capture and marker tracking, one byte per step.
// Depends on pims_pkg.
`default_nettype none

module pims_scan
    import pims_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   beat_byte,
    input  wire logic         beat_last,
    output pims_result_t      result
);

    logic [IDX_W-1:0] idx_reg,      idx_next;
    logic [23:0]      recent_reg,   recent_next;
    logic [LEN_W-1:0] tot_len_reg,  tot_len_next;
    logic [7:0]       ver_ihl_reg,  ver_ihl_next;
    logic [7:0]       proto_reg,    proto_next;
    logic [3:0]       tcp_off_reg,  tcp_off_next;
    logic             fin_reg,      fin_next;
    pims_mark_t       start_reg,    start_next;
    pims_mark_t       end_reg,      end_next;

    logic [31:0]      win;
    logic             in_range;
    logic             hit_soi;
    logic             hit_gif;
    logic             hit_eoi;
    logic [6:0]       pay_start;
    logic             s_ok;
    logic             e_ok;

    assign win = {recent_reg, beat_byte};

    // Header capture; the mark range check sees the length updated this beat
    always_comb
    begin
        tot_len_next = tot_len_reg;
        ver_ihl_next = ver_ihl_reg;
        proto_next   = proto_reg;
        tcp_off_next = tcp_off_reg;
        fin_next     = fin_reg;
        if (idx_reg == POS_VER_IHL)
            ver_ihl_next = beat_byte;
        else if (idx_reg == POS_LEN_HI)
            tot_len_next = {beat_byte, tot_len_reg[7:0]};
        else if (idx_reg == POS_LEN_LO)
            tot_len_next = {tot_len_reg[15:8], beat_byte};
        else if (idx_reg == POS_PROTO)
            proto_next = beat_byte;
        else if (idx_reg == POS_TCP_OFF)
            tcp_off_next = beat_byte[7:4];
        else if (idx_reg == POS_TCP_FLAG)
            fin_next = beat_byte[0];
    end

    assign in_range = idx_reg < tot_len_next;
    assign hit_soi  = (idx_reg >= 16'd2) && (win[23:0] == JPEG_SOI);
    assign hit_gif  = (idx_reg >= 16'd3) && (win == GIF_SIG);
    assign hit_eoi  = (idx_reg >= 16'd1) && (win[15:0] == JPEG_EOI);

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        if (in_range)
        begin
            if (hit_gif)
                start_next = '{valid: 1'b1, offset: idx_reg - 16'd3};
            else if (hit_soi)
                start_next = '{valid: 1'b1, offset: idx_reg - 16'd2};
            if (hit_eoi)
                end_next = '{valid: 1'b1, offset: idx_reg + 16'd1};
        end
    end

    assign recent_next = win[23:0];
    assign idx_next    = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + 16'd1;

    // Result from the state as it stands after this beat
    assign pay_start = IP_HDR_LEN + {1'b0, tcp_off_next, 2'b00};
    assign s_ok = start_next.valid && (start_next.offset >= {9'd0, pay_start});
    assign e_ok = end_next.valid && (end_next.offset >= ({9'd0, pay_start} + 16'd2));

    always_comb
    begin
        result.accepted     = (proto_next == PROTO_TCP) && (ver_ihl_next[3:0] == IHL_MIN);
        result.start_found  = s_ok;
        result.start_offset = s_ok ? start_next.offset : '0;
        if (fin_next)
        begin
            result.end_found  = 1'b1;
            result.end_offset = tot_len_next;
        end
        else
        begin
            result.end_found  = e_ok;
            result.end_offset = e_ok ? end_next.offset : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            recent_reg  <= '0;
            tot_len_reg <= '0;
            ver_ihl_reg <= '0;
            proto_reg   <= '0;
            tcp_off_reg <= '0;
            fin_reg     <= 1'b0;
            start_reg   <= '0;
            end_reg     <= '0;
        end
        else if (step)
        begin
            if (beat_last)
            begin
                idx_reg     <= '0;
                recent_reg  <= '0;
                tot_len_reg <= '0;
                ver_ihl_reg <= '0;
                proto_reg   <= '0;
                tcp_off_reg <= '0;
                fin_reg     <= 1'b0;
                start_reg   <= '0;
                end_reg     <= '0;
            end
            else
            begin
                idx_reg     <= idx_next;
                recent_reg  <= recent_next;
                tot_len_reg <= tot_len_next;
                ver_ihl_reg <= ver_ihl_next;
                proto_reg   <= proto_next;
                tcp_off_reg <= tcp_off_next;
                fin_reg     <= fin_next;
                start_reg   <= start_next;
                end_reg     <= end_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/packet_image_marker_scanner.sv
// packet_image_marker_scanner: top level with input beat register and result register.
// Depends on pims_pkg, pims_in_if, pims_out_if, pims_scan.
//
// Usage:
//   pkt carries the bytes of one IPv4 packet, one byte per beat, pkt_last on
//   the final byte. res carries one result beat per packet: TCP/IHL=5 flag,
//   last image start mark offset and last JPEG end offset (or total length
//   when FIN is set), both counted from the first header byte.
//   Throughput: one byte per cycle unless a last byte stalls. A beat lands
//   in the input register and is scanned from there; the result for a last
//   byte is registered in the result register as that beat leaves the input
//   register, and res takes that result from the result register.
//   The input side keeps taking bytes while a result waits on res; only a
//   further last byte stalls until the pending result is taken, and that
//   stall reaches pkt.ready combinationally through the input register.
//   Reset clears the packet state and both valid flags; after a result the
//   scanner returns to its reset state for the next packet.
`default_nettype none

module packet_image_marker_scanner
    import pims_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pims_in_if.sink     pkt,
    pims_out_if.source  res
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    pims_result_t out_data_reg;
    pims_result_t scan_result;
    logic         out_free;
    logic         step;

    assign out_free  = !out_valid_reg || res.ready;
    assign step      = in_valid_reg && (!in_last_reg || out_free);
    assign pkt.ready = !in_valid_reg || step;

    pims_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .beat_byte (in_byte_reg),
        .beat_last (in_last_reg),
        .result    (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pkt.ready)
                in_valid_reg <= pkt.valid;
            if (step && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            in_byte_reg <= pkt.pkt_byte;
            in_last_reg <= pkt.pkt_last;
        end
        if (step && in_last_reg)
            out_data_reg <= scan_result;
    end

    assign res.valid        = out_valid_reg;
    assign res.accepted     = out_data_reg.accepted;
    assign res.start_found  = out_data_reg.start_found;
    assign res.start_offset = out_data_reg.start_offset;
    assign res.end_found    = out_data_reg.end_found;
    assign res.end_offset   = out_data_reg.end_offset;

    // A pending result is never overwritten by the next packet's last byte
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |-> !(step && in_last_reg))
        else $error("pending result overwritten");

    // A new result appears only after a last byte was scanned
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(step && in_last_reg))
        else $error("result without last byte");

    // A held input beat stays put until scanned
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_last_reg)))
        else $error("input beat lost while stalled");

    // A scanned last byte always yields a result beat
    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_last_reg) |=> out_valid_reg)
        else $error("last byte gave no result");

endmodule

`default_nettype wire

>>> bench/tb.sv
// tb: self-checking bench for packet_image_marker_scanner; streams IPv4 packets byte by byte
// and checks every per-packet result against a cycle-free model of the header/marker scan.
// Depends on pims_pkg, pims_in_if, pims_out_if and the scanner RTL.
`default_nettype none

module tb
    import pims_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {MK_SOI, MK_GIF, MK_EOI} mark_kind_e;

    // Tracks one packet at a time and predicts the result the scanner reports on its last byte.
    class marker_scoreboard;
        logic [15:0]  byte_pos;
        logic [23:0]  window;
        logic [15:0]  ip_len;
        logic [7:0]   ver_ihl;
        logic [7:0]   proto;
        logic [3:0]   data_off;
        logic         fin;
        pims_mark_t   start_rec;
        pims_mark_t   end_rec;
        pims_result_t predicted_reports[$];
        int           mismatches;

        function new();
            mismatches = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_pos  = '0;
            window    = '0;
            ip_len    = '0;
            ver_ihl   = '0;
            proto     = '0;
            data_off  = '0;
            fin       = 1'b0;
            start_rec = '0;
            end_rec   = '0;
        endfunction

        function void absorb_byte(input logic [7:0] octet, input logic last_flag);
            logic [31:0]  win;
            int           payload_at;
            bit           start_ok;
            bit           end_ok;
            pims_result_t rpt;
            win = {window, octet};
            if (byte_pos == POS_VER_IHL) ver_ihl = octet;
            else if (byte_pos == POS_LEN_HI) ip_len[15:8] = octet;
            else if (byte_pos == POS_LEN_LO) ip_len[7:0] = octet;
            else if (byte_pos == POS_PROTO) proto = octet;
            else if (byte_pos == POS_TCP_OFF) data_off = octet[7:4];
            else if (byte_pos == POS_TCP_FLAG) fin = octet[0];
            if (byte_pos < ip_len) begin
                if (byte_pos >= 16'd2 && win[23:0] == JPEG_SOI) begin
                    start_rec.valid  = 1'b1;
                    start_rec.offset = byte_pos - 16'd2;
                end
                if (byte_pos >= 16'd3 && win == GIF_SIG) begin
                    start_rec.valid  = 1'b1;
                    start_rec.offset = byte_pos - 16'd3;
                end
                if (byte_pos >= 16'd1 && win[15:0] == JPEG_EOI) begin
                    end_rec.valid  = 1'b1;
                    end_rec.offset = byte_pos + 16'd1;
                end
            end
            window = win[23:0];
            if (byte_pos != IDX_MAX) byte_pos++;
            if (!last_flag) return;

            payload_at = int'(IP_HDR_LEN) + 4 * int'(data_off);
            start_ok = start_rec.valid && int'(start_rec.offset) >= payload_at;
            // end offset points past FF D9, so the whole mark needs P+2
            end_ok = end_rec.valid && int'(end_rec.offset) >= payload_at + 2;
            rpt.accepted     = (proto == PROTO_TCP) && (ver_ihl[3:0] == IHL_MIN);
            rpt.start_found  = start_ok;
            rpt.start_offset = start_ok ? start_rec.offset : 16'd0;
            if (fin) begin
                rpt.end_found  = 1'b1;
                rpt.end_offset = ip_len;
            end
            else begin
                rpt.end_found  = end_ok;
                rpt.end_offset = end_ok ? end_rec.offset : 16'd0;
            end
            predicted_reports.push_back(rpt);
            clear_packet();
        endfunction

        function void compare_report(input pims_result_t got);
            pims_result_t want;
            if (predicted_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: acc=%0b sf=%0b so=%0d ef=%0b eo=%0d",
                             got.accepted, got.start_found, got.start_offset,
                             got.end_found, got.end_offset);
                return;
            end
            want = predicted_reports.pop_front();
            if (got.accepted !== want.accepted || got.start_found !== want.start_found ||
                got.start_offset !== want.start_offset || got.end_found !== want.end_found ||
                got.end_offset !== want.end_offset) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp acc=%0b sf=%0b so=%0d ef=%0b eo=%0d",
                             want.accepted, want.start_found, want.start_offset,
                             want.end_found, want.end_offset,
                             " | got acc=%0b sf=%0b so=%0d ef=%0b eo=%0d",
                             got.accepted, got.start_found, got.start_offset,
                             got.end_found, got.end_offset);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pims_in_if  pkt_ch();
    pims_out_if res_ch();

    packet_image_marker_scanner uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .res   (res_ch)
    );

    marker_scoreboard sb = new();

    logic [7:0] frame[$];
    bit         calm_source = 1'b0;
    bit         calm_sink   = 1'b0;
    int         hold_cycles = 0;
    int         bytes_sent  = 0;
    int         frames_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        pims_result_t got;
        if (rst_n) begin
            if (pkt_ch.valid && pkt_ch.ready)
                sb.absorb_byte(pkt_ch.pkt_byte, pkt_ch.pkt_last);
            if (res_ch.valid && res_ch.ready) begin
                got.accepted     = res_ch.accepted;
                got.start_found  = res_ch.start_found;
                got.start_offset = res_ch.start_offset;
                got.end_found    = res_ch.end_found;
                got.end_offset   = res_ch.end_offset;
                sb.compare_report(got);
            end
        end
    end

    // Result side: random back-pressure, or a counted hold-off when requested.
    initial
    begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                res_ch.ready <= calm_sink || ($urandom_range(99) >= 19);
        end
    end

    function automatic logic [7:0] rand_octet();
        case ($urandom_range(9))
            0, 1: return JPEG_SOI[23:16];
            2:    return JPEG_SOI[15:8];
            3:    return JPEG_EOI[7:0];
            4:    return GIF_SIG[31:24];
            5:    return GIF_SIG[23:16];
            6:    return GIF_SIG[15:8];
            7:    return GIF_SIG[7:0];
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void fill_frame(input int n, input bit quiet);
        frame.delete();
        repeat (n) frame.push_back(quiet ? 8'h00 : rand_octet());
    endfunction

    function automatic void put(input int pos, input logic [7:0] v);
        if (pos >= 0 && pos < frame.size()) frame[pos] = v;
    endfunction

    function automatic void set_header(input logic [7:0] vi, input logic [15:0] len,
                                       input logic [7:0] pr, input logic [3:0] doff,
                                       input logic fin_flag);
        logic [7:0] flags;
        flags = 8'($urandom);
        put(int'(POS_VER_IHL), vi);
        put(int'(POS_LEN_HI), len[15:8]);
        put(int'(POS_LEN_LO), len[7:0]);
        put(int'(POS_PROTO), pr);
        put(int'(POS_TCP_OFF), {doff, 4'($urandom)});
        put(int'(POS_TCP_FLAG), {flags[7:1], fin_flag});
    endfunction

    function automatic void plant(input int pos, input mark_kind_e kind);
        case (kind)
            MK_SOI: begin
                put(pos, JPEG_SOI[23:16]);
                put(pos + 1, JPEG_SOI[15:8]);
                put(pos + 2, JPEG_SOI[7:0]);
            end
            MK_GIF: begin
                put(pos, GIF_SIG[31:24]);
                put(pos + 1, GIF_SIG[23:16]);
                put(pos + 2, GIF_SIG[15:8]);
                put(pos + 3, GIF_SIG[7:0]);
            end
            default: begin
                put(pos, JPEG_EOI[15:8]);
                put(pos + 1, JPEG_EOI[7:0]);
            end
        endcase
    endfunction

    function automatic void build_random_packet();
        int          n;
        int          doff_i;
        int          p;
        logic [15:0] len;
        logic [7:0]  vi;
        logic [7:0]  pr;
        logic        fin_flag;
        if ($urandom_range(99) < 25) begin
            n = $urandom_range(1, 40);
            frame.delete();
            repeat (n) frame.push_back(8'($urandom));
            return;
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(34, 100);
        doff_i = ($urandom_range(9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        p = 20 + 4 * doff_i;
        case ($urandom_range(19))
            0, 1, 2: len = 16'($urandom_range(0, n));
            3, 4, 5: len = 16'(n + $urandom_range(1, 60));
            6:       len = 16'($urandom);
            default: len = 16'(n);
        endcase
        vi = ($urandom_range(99) < 20) ? 8'($urandom) : {4'd4, IHL_MIN};
        pr = ($urandom_range(99) < 20) ? 8'($urandom) : PROTO_TCP;
        fin_flag = ($urandom_range(4) == 0);
        fill_frame(n, 1'b0);
        set_header(vi, len, pr, 4'(doff_i), fin_flag);
        repeat ($urandom_range(0, 3))
            plant($urandom_range(p > 4 ? p - 4 : 0, n - 1), mark_kind_e'($urandom_range(2)));
    endfunction

    task automatic drive_byte(input logic [7:0] octet, input logic last_flag);
        while (!calm_source && $urandom_range(99) < 19) begin
            @(negedge clk);
            pkt_ch.valid <= 1'b0;
        end
        @(negedge clk);
        pkt_ch.valid    <= 1'b1;
        pkt_ch.pkt_byte <= octet;
        pkt_ch.pkt_last <= last_flag;
        do @(posedge clk); while (!pkt_ch.ready);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame.size(); i++) begin
            drive_byte(frame[i], i == frame.size() - 1);
            bytes_sent++;
        end
        frames_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        while (sb.predicted_reports.size() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        // one-byte packet: header never completes
        frame.delete();
        frame.push_back({4'd4, IHL_MIN});
        send_frame();
        // plain TCP packet with a start and an end mark
        fill_frame(60, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd60, PROTO_TCP, 4'd5, 1'b0);
        plant(40, MK_SOI);
        plant(50, MK_EOI);
        send_frame();
        // GIF8 cut by the total length, earlier JPEG start still counts
        fill_frame(60, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd59, PROTO_TCP, 4'd5, 1'b0);
        plant(44, MK_SOI);
        plant(56, MK_GIF);
        send_frame();
        // GIF8 ending exactly on the total length
        fill_frame(60, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd60, PROTO_TCP, 4'd5, 1'b0);
        plant(56, MK_GIF);
        send_frame();
        // marks inside TCP options, before the payload
        fill_frame(70, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd70, PROTO_TCP, 4'd8, 1'b0);
        plant(40, MK_SOI);
        plant(45, MK_EOI);
        send_frame();
        // marks straddling the payload start
        fill_frame(50, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd50, PROTO_TCP, 4'd5, 1'b0);
        plant(38, MK_SOI);
        plant(39, MK_EOI);
        send_frame();
        // FIN, no marks
        fill_frame(48, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd48, PROTO_TCP, 4'd5, 1'b1);
        send_frame();
        // FIN overrides a real end mark, length differs from byte count
        fill_frame(64, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd90, PROTO_TCP, 4'd5, 1'b1);
        plant(42, MK_EOI);
        send_frame();
        // rejected: not TCP
        fill_frame(60, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd60, 8'd17, 4'd5, 1'b0);
        plant(41, MK_GIF);
        plant(50, MK_EOI);
        send_frame();
        // rejected: IP options present
        fill_frame(60, 1'b1);
        set_header(8'h46, 16'd60, PROTO_TCP, 4'd5, 1'b0);
        plant(45, MK_SOI);
        send_frame();
        // marks past the total length are ignored
        fill_frame(80, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd50, PROTO_TCP, 4'd5, 1'b0);
        plant(42, MK_EOI);
        plant(60, MK_SOI);
        plant(70, MK_EOI);
        send_frame();
        // several marks, the last start mark and the last end mark win
        fill_frame(90, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd90, PROTO_TCP, 4'd5, 1'b0);
        plant(40, MK_SOI);
        plant(45, MK_EOI);
        plant(50, MK_GIF);
        plant(60, MK_SOI);
        plant(70, MK_EOI);
        send_frame();
        // zero data offset puts the payload right after the IP header
        fill_frame(40, 1'b1);
        set_header({4'd4, IHL_MIN}, 16'd40, PROTO_TCP, 4'd0, 1'b0);
        plant(21, MK_SOI);
        plant(26, MK_EOI);
        send_frame();
        // all ones, then all zeros
        frame.delete();
        repeat (100) frame.push_back(8'hff);
        send_frame();
        fill_frame(40, 1'b1);
        send_frame();
    endtask

    initial
    begin
        int random_frames;
        rst_n           = 1'b0;
        pkt_ch.valid    = 1'b0;
        pkt_ch.pkt_byte = 8'h00;
        pkt_ch.pkt_last = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain();

        random_frames = 0;
        while (bytes_sent < 1550) begin
            calm_source = (random_frames >= 2 && random_frames < 7);
            calm_sink   = calm_source;
            if (random_frames == 1) begin
                // stall the result side while tiny packets pile up on the input
                hold_cycles = 400;
                repeat (30) begin
                    frame.delete();
                    repeat ($urandom_range(1, 2)) frame.push_back(8'($urandom));
                    send_frame();
                end
            end
            if (random_frames == 7)
                drain();
            build_random_packet();
            send_frame();
            random_frames++;
        end

        calm_sink = 1'b1;
        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/pims_pkg.sv
rtl/pims_in_if.sv
rtl/pims_out_if.sv
rtl/pims_scan.sv
rtl/packet_image_marker_scanner.sv
bench/tb.sv
